@@ rtl/core/sea_pkg.sv @@
// ----------------------------------------------------------------------------
// sea_pkg
// Shared types and constants for the seam energy accumulator.
// ----------------------------------------------------------------------------
package sea_pkg;

  // Width of the row width register and its value after reset.
  localparam int unsigned CFG_W           = 11;
  localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 11'd1024;

  // Width of one cumulative energy value and of a line store entry.
  localparam int unsigned CUM_W   = 32;
  localparam logic [CUM_W-1:0] CUM_MAX = '1;

  // Row position flags of one pixel, from the column tracker.
  typedef struct packed {
    logic first_row;  // pixel lies in the first row streamed of its image
    logic row_end;    // pixel is the last one of its row
  } row_pos_t;

endpackage

@@ rtl/core/sea_col_ctrl.sv @@
// ----------------------------------------------------------------------------
// sea_col_ctrl
// Row width register and column / first-row tracking for accepted pixels.
// ----------------------------------------------------------------------------
module sea_col_ctrl #(
  parameter int unsigned MAX_ROW_WIDTH = 1024,
  parameter int unsigned AW            = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic [sea_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                    accept_i,
  input  logic                    frame_start_i,
  output logic [AW-1:0]           col_o,
  output sea_pkg::row_pos_t       pos_o
);
  import sea_pkg::*;

  localparam int unsigned CMPW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_ROW_WIDTH);

  logic [CFG_W-1:0] row_width_q;
  logic [AW-1:0]    col_count_q, col_count_d;
  logic             first_row_q, first_row_d;
  logic [CMPW-1:0]  width_raw, width_eff, col_next;
  logic [AW-1:0]    col;
  logic             first_row;
  logic             row_end;

  always_comb begin
    width_raw = CMPW'(row_width_q);
    if (width_raw == '0) begin
      width_eff = CMPW'(1);
    end else if (width_raw > MAX_W) begin
      width_eff = MAX_W;
    end else begin
      width_eff = width_raw;
    end
  end

  // A frame start restarts the column count and first-row mode.
  assign col       = frame_start_i ? '0 : col_count_q;
  assign first_row = frame_start_i | first_row_q;
  assign col_next  = CMPW'(col) + CMPW'(1);
  assign row_end   = (col_next >= width_eff);

  always_comb begin
    col_count_d = row_end ? '0 : AW'(col_next);
    first_row_d = row_end ? 1'b0 : first_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RESET;
      col_count_q <= '0;
      first_row_q <= 1'b1;
    end else begin
      if (cfg_valid_i) begin
        row_width_q <= cfg_data_i;
      end
      if (accept_i) begin
        col_count_q <= col_count_d;
        first_row_q <= first_row_d;
      end
    end
  end

  assign col_o           = col;
  assign pos_o.first_row = first_row;
  assign pos_o.row_end   = row_end;

endmodule

@@ rtl/core/sea_line_store.sv @@
// ----------------------------------------------------------------------------
// sea_line_store
// Previous-row store: one write port, two registered read ports, with
// bypass of a write that lands on the same edge as a read.
// ----------------------------------------------------------------------------
module sea_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_a_i,
  input  logic [AW-1:0]             rd_addr_b_i,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [sea_pkg::CUM_W-1:0] wr_data_i,
  output logic [sea_pkg::CUM_W-1:0] rd_data_a_o,
  output logic [sea_pkg::CUM_W-1:0] rd_data_b_o
);
  import sea_pkg::*;

  logic [CUM_W-1:0] mem [DEPTH];
  logic [CUM_W-1:0] rd_data_a_q, rd_data_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_q <= (wr_en_i && wr_addr_i == rd_addr_a_i) ? wr_data_i : mem[rd_addr_a_i];
      rd_data_b_q <= (wr_en_i && wr_addr_i == rd_addr_b_i) ? wr_data_i : mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_data_a_q;
  assign rd_data_b_o = rd_data_b_q;

endmodule

@@ rtl/core/sea_min_add.sv @@
// ----------------------------------------------------------------------------
// sea_min_add
// Three-way minimum over the previous row's neighbours plus a saturating add
// of the pixel energy; a pixel of the first row gives its own energy alone.
// ----------------------------------------------------------------------------
module sea_min_add #(
  parameter int unsigned ENERGY_BITS = 12
) (
  input  logic [ENERGY_BITS-1:0]    energy_i,
  input  sea_pkg::row_pos_t         pos_i,
  input  logic                      col_zero_i,
  input  logic [sea_pkg::CUM_W-1:0] left_i,
  input  logic [sea_pkg::CUM_W-1:0] above_i,
  input  logic [sea_pkg::CUM_W-1:0] right_i,
  output logic [sea_pkg::CUM_W-1:0] cum_o
);
  import sea_pkg::*;

  logic [CUM_W-1:0] best_lc, best;
  logic [CUM_W:0]   sum;

  always_comb begin
    // Drop neighbours that fall outside the row.
    best_lc = (!col_zero_i && left_i < above_i) ? left_i : above_i;
    best    = (!pos_i.row_end && right_i < best_lc) ? right_i : best_lc;
    sum     = (CUM_W+1)'(energy_i) + (CUM_W+1)'(best);
    if (pos_i.first_row) begin
      cum_o = CUM_W'(energy_i);
    end else if (sum[CUM_W]) begin
      cum_o = CUM_MAX;
    end else begin
      cum_o = sum[CUM_W-1:0];
    end
  end

endmodule

@@ rtl/core/seam_energy_accumulator.sv @@
// ----------------------------------------------------------------------------
// seam_energy_accumulator
// Cumulative seam energy map over a raster stream of pixel energies.
// ----------------------------------------------------------------------------
// Pixels arrive bottom row first. A pixel of the first row streamed gives its
// own energy; any later pixel gives its energy plus the least of the up to
// three neighbours (column-1, column, column+1) in the previous row, sum
// saturating at 0xFFFFFFFF. Assert tuser with the bottom-left pixel of each
// image to restart the column and first-row tracking; without it, the stream
// after reset counts as a first row from column 0. The row width register
// (write on the cfg channel while idle) takes 1..MAX_ROW_WIDTH; 0 acts as 1
// and larger values act as MAX_ROW_WIDTH. Throughput is one pixel per clock
// while m_axis_tready_i is high: the line store is read at the accept beat
// (two ports, current and right column), the minimum and add run in the
// next stage, and the result is then registered in the output register. The
// output register lets one more pixel enter the compute stage while a result
// waits for m_axis_tready_i. The line store is not cleared after reset; a row
// never reads an entry that the previous row of the same width did not write.
// ----------------------------------------------------------------------------
module seam_energy_accumulator #(
  parameter int unsigned MAX_ROW_WIDTH = 1024,
  parameter int unsigned ENERGY_BITS   = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Pixel input stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [((ENERGY_BITS+7)/8)*8-1:0] s_axis_tdata_i,  // pixel_energy
  input  logic                      s_axis_tuser_i,         // frame_start
  // Result stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [sea_pkg::CUM_W-1:0] m_axis_tdata_o,         // cumulative_energy
  output logic                      m_axis_tlast_o,         // row_end
  // Row width register write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sea_pkg::CFG_W-1:0] cfg_data_i
);
  import sea_pkg::*;

  localparam int unsigned AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;

  // Handshake
  logic accept;
  logic s1_advance;

  // Column tracker outputs for the beat at the input
  logic [AW-1:0] in_col;
  row_pos_t      in_pos;
  logic [AW-1:0] rd_addr_right;

  // Compute stage registers
  logic                   s1_valid_q;
  logic [AW-1:0]          s1_col_q;
  row_pos_t               s1_pos_q;
  logic [ENERGY_BITS-1:0] s1_energy_q;
  logic [CUM_W-1:0]       s1_left_q;

  // Line store read data for the pixel in the compute stage
  logic [CUM_W-1:0] above, right;
  logic [CUM_W-1:0] s1_cum;

  // Output register
  logic             out_valid_q;
  logic [CUM_W-1:0] out_cum_q;
  logic             out_last_q;

  // Advance the compute stage when the output register is free or draining.
  assign s1_advance      = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  sea_col_ctrl #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .AW            (AW)
  ) u_col_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .frame_start_i (s_axis_tuser_i),
    .col_o         (in_col),
    .pos_o         (in_pos)
  );

  // The right neighbour is unused at row end; hold the address in range then.
  assign rd_addr_right = in_pos.row_end ? in_col : in_col + AW'(1);

  // The pixel leaving the compute stage writes on the same edge that the next
  // pixel reads; the store bypasses that write.
  sea_line_store #(
    .DEPTH (MAX_ROW_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_addr_a_i (in_col),
    .rd_addr_b_i (rd_addr_right),
    .wr_en_i     (s1_advance),
    .wr_addr_i   (s1_col_q),
    .wr_data_i   (s1_cum),
    .rd_data_a_o (above),
    .rd_data_b_o (right)
  );

  sea_min_add #(
    .ENERGY_BITS (ENERGY_BITS)
  ) u_min_add (
    .energy_i   (s1_energy_q),
    .pos_i      (s1_pos_q),
    .col_zero_i (s1_col_q == '0),
    .left_i     (s1_left_q),
    .above_i    (above),
    .right_i    (right),
    .cum_o      (s1_cum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers. The left neighbour of a pixel is the value read above
  // the pixel before it, which still sits in the store's read register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q    <= in_col;
      s1_pos_q    <= in_pos;
      s1_energy_q <= s_axis_tdata_i[ENERGY_BITS-1:0];
      s1_left_q   <= above;
    end
    if (s1_advance) begin
      out_cum_q  <= s1_cum;
      out_last_q <= s1_pos_q.row_end;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_cum_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
